FILE: hw/rtl/bounded_deque_with_search_macros.svh
// Assertion macros for the deque RTL.
`ifndef BOUNDED_DEQUE_WITH_SEARCH_MACROS_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_MACROS_SVH

`ifndef ASSERT_OFF

// Condition holds in the same cycle as the trigger.
`define BDQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Condition holds in the cycle after the trigger.
`define BDQ_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define BDQ_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define BDQ_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

FILE: hw/rtl/bdq_pkg.sv
package bdq_pkg;

    // Default sizing
    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Command codes
    localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [2:0] CMD_POP_BACK   = 3'd3;
    localparam logic [2:0] CMD_SEARCH     = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    localparam logic [3:0] POS_MAX = 4'd15;

    typedef struct packed {
        logic        [2:0]  command;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        logic        [1:0]  status;
        logic signed [31:0] data;
        logic        [3:0]  position;
        logic        [4:0]  occupancy;
    } t_out;

    // Per-cycle control broadcast to every cell
    typedef struct packed {
        logic load;       // cell whose index matches takes the load data
        logic shift;      // every cell takes a neighbor
        logic from_left;  // neighbor select: left (toward front) or right (toward back)
    } t_cell_ctrl;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_WALK = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

endpackage

FILE: hw/rtl/bdq_cell.sv
module bdq_cell
    import bdq_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int IDX_W      = 4,
    parameter int INDEX      = 0
) (
    input  logic                         i_clk,
    input  t_cell_ctrl                   i_ctrl,
    input  logic [IDX_W-1:0]             i_load_idx,
    input  logic signed [DATA_WIDTH-1:0] i_load_data,
    input  logic signed [DATA_WIDTH-1:0] i_left,
    input  logic signed [DATA_WIDTH-1:0] i_right,
    output logic signed [DATA_WIDTH-1:0] o_q
);

    logic signed [DATA_WIDTH-1:0] r_q;
    logic signed [DATA_WIDTH-1:0] n_q;

    // Pick the next entry: neighbor on a shift, load data on an index hit, else hold
    always_comb begin
        n_q = r_q;
        if (i_ctrl.shift) begin
            n_q = i_ctrl.from_left ? i_left : i_right;
        end else if (i_ctrl.load && (i_load_idx == IDX_W'(INDEX))) begin
            n_q = i_load_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

FILE: hw/rtl/bounded_deque_with_search.sv
// Bounded deque of signed words with a front-to-back search, built as a ring
// of DEPTH cells with the front entry in cell 0 between items. Push front, push back,
// pop front and the full/empty refusals pass from the accepted item to a result
// in the output register through accept, execute and deliver. Pop back and
// search rotate the whole cell ring once through cell 0, one entry per cycle,
// whatever the occupancy. One item is in work at
// a time; the next item is taken as soon as the previous result sits in the
// output register, even while that result is stalled. Entries hold no reset
// value and need no clearing pass.
`include "bounded_deque_with_search_macros.svh"

module bounded_deque_with_search
    import bdq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out
);

    localparam int SW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [SW-1:0] STEP_LAST = SW'(DEPTH - 1);

    // Control state
    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [SW-1:0]      r_step,  n_step;
    logic               r_hit,   n_hit;
    logic               r_out_valid, n_out_valid;

    // Item and result payload
    logic [2:0]                   r_cmd, n_cmd;
    logic signed [DATA_WIDTH-1:0] r_val, n_val;
    logic [1:0]                   r_status, n_status;
    logic signed [DATA_WIDTH-1:0] r_data, n_data;
    logic [3:0]                   r_pos, n_pos;
    t_out                         r_out, n_out;

    t_cell_ctrl                   cell_ctrl;
    logic signed [DATA_WIDTH-1:0] cell_q [DEPTH];

    logic full;
    logic empty;
    logic out_free;
    logic in_acc;
    logic entry_ge;
    logic entry_eq;
    logic in_range;
    logic walk_last;
    logic out_load;

    function automatic logic [3:0] sat_pos(input logic [CW-1:0] x);
        if (32'(x) > 32'(POS_MAX)) begin
            return POS_MAX;
        end else begin
            return 4'(x);
        end
    endfunction

    // Cell ring: cell 0 takes new front entries, cell 0 wraps to the last cell
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        bdq_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IDX_W      (SW),
            .INDEX      (gi)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (cell_ctrl),
            .i_load_idx  (SW'(r_count)),
            .i_load_data (r_val),
            .i_left      ((gi == 0) ? r_val : cell_q[(gi + DEPTH - 1) % DEPTH]),
            .i_right     (cell_q[(gi + 1) % DEPTH]),
            .o_q         (cell_q[gi])
        );
    end

    assign full       = (r_count == CW'(DEPTH));
    assign empty      = (r_count == '0);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign walk_last  = (r_state == S_WALK) && (r_step == STEP_LAST);
    assign out_load   = (r_state == S_DONE) && out_free;

    // Search compare on the entry now in cell 0
    assign entry_ge = !(cell_q[0] < r_val);
    assign entry_eq = (cell_q[0] == r_val);
    assign in_range = (CW'(r_step) < r_count);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_step      = r_step;
        n_hit       = r_hit;
        n_cmd       = r_cmd;
        n_val       = r_val;
        n_status    = r_status;
        n_data      = r_data;
        n_pos       = r_pos;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        cell_ctrl   = '0;

        unique case (r_state)
            // Take the next item
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = i_in.command;
                    n_val   = DATA_WIDTH'(i_in.value);
                    n_state = S_EXEC;
                end
            end

            // Do pushes, pop front and refusals at once, start a ring walk for pop back and search
            S_EXEC: begin
                n_status = ST_OK;
                n_data   = '0;
                n_pos    = '0;
                n_state  = S_DONE;
                unique case (r_cmd)
                    CMD_PUSH_FRONT: begin
                        if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            cell_ctrl.shift     = 1'b1;
                            cell_ctrl.from_left = 1'b1;
                            n_count             = r_count + 1'b1;
                        end
                    end
                    CMD_PUSH_BACK: begin
                        if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            cell_ctrl.load = 1'b1;
                            n_count        = r_count + 1'b1;
                        end
                    end
                    CMD_POP_FRONT: begin
                        if (empty) begin
                            n_status = ST_EMPTY;
                        end else begin
                            cell_ctrl.shift = 1'b1;
                            n_data          = cell_q[0];
                            n_count         = r_count - 1'b1;
                        end
                    end
                    CMD_POP_BACK: begin
                        if (empty) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_step  = '0;
                            n_state = S_WALK;
                        end
                    end
                    CMD_SEARCH: begin
                        n_status = ST_NOT_FOUND;
                        n_pos    = sat_pos(r_count);
                        n_hit    = 1'b0;
                        n_step   = '0;
                        n_state  = S_WALK;
                    end
                    default: begin
                    end
                endcase
            end

            // Rotate the ring by one; cell 0 holds the entry at index r_step
            S_WALK: begin
                cell_ctrl.shift = 1'b1;
                n_step          = r_step + 1'b1;
                if (r_cmd == CMD_POP_BACK) begin
                    if (CW'(r_step) == r_count - 1'b1) begin
                        n_data = cell_q[0];
                    end
                end else if (!r_hit && in_range && entry_ge) begin
                    n_hit = 1'b1;
                    n_pos = sat_pos(CW'(r_step));
                    if (entry_eq) begin
                        n_status = ST_OK;
                        n_data   = cell_q[0];
                    end
                end
                if (r_step == STEP_LAST) begin
                    n_state = S_DONE;
                    if (r_cmd == CMD_POP_BACK) begin
                        n_count = r_count - 1'b1;
                    end
                end
            end

            // Hand the result to the output register
            S_DONE: begin
                if (out_free) begin
                    n_out_valid     = 1'b1;
                    n_out.status    = r_status;
                    n_out.data      = 32'(r_data);
                    n_out.position  = r_pos;
                    n_out.occupancy = 5'(r_count);
                    n_state         = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_step      <= '0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_step      <= n_step;
            r_hit       <= n_hit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_val    <= n_val;
        r_status <= n_status;
        r_data   <= n_data;
        r_pos    <= n_pos;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Checks
    `BDQ_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH))
    `BDQ_ASSERT_NXT(a_accept_exec, i_clk, i_rst_n, in_acc, r_state == S_EXEC)
    `BDQ_ASSERT_NXT(a_walk_end, i_clk, i_rst_n, walk_last, r_state == S_DONE)
    `BDQ_ASSERT_NXT(a_done_out, i_clk, i_rst_n, out_load, o_out_valid && r_state == S_IDLE)

endmodule
